### rtl/pgoc_pkg.sv
// Package: grid geometry, field widths, register codes and controller types.
`default_nettype none
package pgoc_pkg;

    localparam int GRID_COLUMNS = 256;
    localparam int GRID_ROWS    = 256;
    localparam int COUNT_BITS   = 8;

    localparam int CELL_TOTAL = GRID_COLUMNS * GRID_ROWS;
    localparam int ADDR_BITS  = $clog2(CELL_TOTAL);
    localparam int COL_BITS   = $clog2(GRID_COLUMNS);
    localparam int ROW_BITS   = $clog2(GRID_ROWS);

    localparam int COORD_W    = 20;
    localparam int OFFSET_W   = COORD_W + 1;
    localparam int INV_W      = 16;
    localparam int CSIZE_W    = 16;
    localparam int THRESH_W   = 8;
    localparam int IDX_OUT_W  = 8;
    localparam int BIN_PROD_W = COORD_W + INV_W;
    localparam int BIN_SHIFT  = 18;
    localparam int QUOT_W     = BIN_PROD_W - BIN_SHIFT;
    localparam int CMP_W      = (COUNT_BITS > THRESH_W) ? COUNT_BITS : THRESH_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X       = 3'd0,
        CFG_ORIGIN_Y       = 3'd1,
        CFG_INV_CELL_SIZE  = 3'd2,
        CFG_CELL_SIZE      = 3'd3,
        CFG_COUNT_THRESH   = 3'd4
    } t_cfg_idx;

    localparam logic [COORD_W-1:0]  ORIGIN_RESET = 20'hFD800;
    localparam logic [INV_W-1:0]    INV_RESET    = 16'd5120;
    localparam logic [CSIZE_W-1:0]  CSIZE_RESET  = 16'd51;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd10;

    typedef struct packed {
        logic clear_wr;
        logic accept;
        logic mul;
        logic bin;
        logic inc;
        logic scan_rd;
        logic scan_wr;
        logic out_load;
    } t_pgoc_cmd;

    typedef struct packed {
        logic clear_last;
        logic in_range;
        logic out_free;
    } t_pgoc_sts;

endpackage
`default_nettype wire

### rtl/pgoc_if.sv
// Interfaces: point input channel, readout result channel and register write channel.
`default_nettype none
interface pgoc_in_if;
    import pgoc_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      func;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;

    modport source (output valid, output func, output point_x, output point_y, input ready);
    modport sink   (input valid, input func, input point_x, input point_y, output ready);
endinterface

interface pgoc_out_if;
    import pgoc_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      occupied;
    logic [IDX_OUT_W-1:0]      column;
    logic [IDX_OUT_W-1:0]      row;
    logic signed [COORD_W-1:0] position_x;
    logic signed [COORD_W-1:0] position_y;
    logic                      last_cell;

    modport source (output valid, output occupied, output column, output row,
                    output position_x, output position_y, output last_cell, input ready);
    modport sink   (input valid, input occupied, input column, input row,
                    input position_x, input position_y, input last_cell, output ready);
endinterface

interface pgoc_cfg_if;
    import pgoc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### rtl/pgoc_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module pgoc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

### rtl/pgoc_ctrl.sv
// Controller: sequences the clearing pass, point binning and cell readout.
`default_nettype none
module pgoc_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_func,
    output logic                      o_in_ready,
    input  wire pgoc_pkg::t_pgoc_sts  i_sts,
    output pgoc_pkg::t_pgoc_cmd       o_cmd
);
    import pgoc_pkg::*;

    typedef enum logic [7:0] {
        ST_CLEAR   = 8'b0000_0001,
        ST_IDLE    = 8'b0000_0010,
        ST_MUL     = 8'b0000_0100,
        ST_BIN     = 8'b0000_1000,
        ST_INC     = 8'b0001_0000,
        ST_SCAN_RD = 8'b0010_0000,
        ST_SCAN_WR = 8'b0100_0000,
        ST_OUT     = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_in_func ? ST_SCAN_RD : ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_BIN;
            end
            ST_BIN: begin
                // The count is fetched here; a point off the grid ends at once.
                o_cmd.bin = 1'b1;
                n_state   = i_sts.in_range ? ST_INC : ST_IDLE;
            end
            ST_INC: begin
                o_cmd.inc = 1'b1;
                n_state   = ST_IDLE;
            end
            ST_SCAN_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state       = ST_SCAN_WR;
            end
            ST_SCAN_WR: begin
                o_cmd.scan_wr = 1'b1;
                n_state       = ST_OUT;
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end
endmodule
`default_nettype wire

### rtl/pgoc_dp.sv
// Datapath: registers, binning arithmetic, count memory, scan pointer and result register.
`default_nettype none
module pgoc_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire pgoc_pkg::t_pgoc_cmd                 i_cmd,
    output pgoc_pkg::t_pgoc_sts                      o_sts,
    input  wire logic signed [pgoc_pkg::COORD_W-1:0] i_point_x,
    input  wire logic signed [pgoc_pkg::COORD_W-1:0] i_point_y,
    input  wire logic                                i_cfg_valid,
    input  wire logic [pgoc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [pgoc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic                                     o_occupied,
    output logic [pgoc_pkg::IDX_OUT_W-1:0]           o_column,
    output logic [pgoc_pkg::IDX_OUT_W-1:0]           o_row,
    output logic signed [pgoc_pkg::COORD_W-1:0]      o_position_x,
    output logic signed [pgoc_pkg::COORD_W-1:0]      o_position_y,
    output logic                                     o_last_cell
);
    import pgoc_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Configuration registers.
    logic [COORD_W-1:0]  r_origin_x, r_origin_y;
    logic [INV_W-1:0]    r_inv;
    logic [CSIZE_W-1:0]  r_csize;
    logic [THRESH_W-1:0] r_thresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= ORIGIN_RESET;
            r_origin_y <= ORIGIN_RESET;
            r_inv      <= INV_RESET;
            r_csize    <= CSIZE_RESET;
            r_thresh   <= THRESH_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ORIGIN_X:      r_origin_x <= i_cfg_data[COORD_W-1:0];
                CFG_ORIGIN_Y:      r_origin_y <= i_cfg_data[COORD_W-1:0];
                CFG_INV_CELL_SIZE: r_inv      <= i_cfg_data[INV_W-1:0];
                CFG_CELL_SIZE:     r_csize    <= i_cfg_data[CSIZE_W-1:0];
                CFG_COUNT_THRESH:  r_thresh   <= i_cfg_data[THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    // Binning: offset on accept, magnitude times reciprocal next, then index and range.
    logic [OFFSET_W-1:0]   r_off_x, r_off_y;
    logic [BIN_PROD_W-1:0] r_prod_x, r_prod_y;
    logic                  r_neg_x, r_neg_y;
    logic [COORD_W-1:0]    w_mag_x, w_mag_y;

    assign w_mag_x = COORD_W'(r_off_x[OFFSET_W-1] ? -r_off_x : r_off_x);
    assign w_mag_y = COORD_W'(r_off_y[OFFSET_W-1] ? -r_off_y : r_off_y);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_off_x <= {i_point_x[COORD_W-1], i_point_x} - {r_origin_x[COORD_W-1], r_origin_x};
            r_off_y <= {i_point_y[COORD_W-1], i_point_y} - {r_origin_y[COORD_W-1], r_origin_y};
        end
        if (i_cmd.mul) begin
            r_prod_x <= BIN_PROD_W'(w_mag_x) * BIN_PROD_W'(r_inv);
            r_prod_y <= BIN_PROD_W'(w_mag_y) * BIN_PROD_W'(r_inv);
            r_neg_x  <= r_off_x[OFFSET_W-1];
            r_neg_y  <= r_off_y[OFFSET_W-1];
        end
    end

    logic [QUOT_W-1:0]    w_q_x, w_q_y;
    logic                 w_ok_x, w_ok_y;
    logic [ADDR_BITS-1:0] w_bin_addr;

    assign w_q_x  = r_prod_x[BIN_PROD_W-1:BIN_SHIFT];
    assign w_q_y  = r_prod_y[BIN_PROD_W-1:BIN_SHIFT];
    // A negative offset is inside only when it truncates to index zero.
    assign w_ok_x = !(r_neg_x && (w_q_x != '0)) && (w_q_x < QUOT_W'(GRID_COLUMNS));
    assign w_ok_y = !(r_neg_y && (w_q_y != '0)) && (w_q_y < QUOT_W'(GRID_ROWS));
    assign w_bin_addr = ADDR_BITS'(ADDR_BITS'(w_q_y[ROW_BITS-1:0]) * ADDR_BITS'(GRID_COLUMNS))
                      + ADDR_BITS'(w_q_x[COL_BITS-1:0]);

    assign o_sts.in_range = w_ok_x && w_ok_y;

    logic [ADDR_BITS-1:0] r_addr;
    always_ff @(posedge i_clk) begin
        if (i_cmd.bin) begin
            r_addr <= w_bin_addr;
        end
    end

    // Clearing sweep and scan pointer.
    logic [ADDR_BITS-1:0] r_clr_addr;
    logic [ADDR_BITS-1:0] r_scan_addr;
    logic [COL_BITS-1:0]  r_scan_col;
    logic [ROW_BITS-1:0]  r_scan_row;
    logic                 w_scan_last;

    assign o_sts.clear_last = (r_clr_addr == ADDR_BITS'(CELL_TOTAL - 1));
    assign w_scan_last      = (r_scan_addr == ADDR_BITS'(CELL_TOTAL - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_scan_addr <= '0;
            r_scan_col  <= '0;
            r_scan_row  <= '0;
        end else begin
            if (i_cmd.clear_wr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.scan_wr) begin
                if (w_scan_last) begin
                    r_scan_addr <= '0;
                    r_scan_col  <= '0;
                    r_scan_row  <= '0;
                end else begin
                    r_scan_addr <= r_scan_addr + 1'b1;
                    if (r_scan_col == COL_BITS'(GRID_COLUMNS - 1)) begin
                        r_scan_col <= '0;
                        r_scan_row <= r_scan_row + 1'b1;
                    end else begin
                        r_scan_col <= r_scan_col + 1'b1;
                    end
                end
            end
        end
    end

    // Count memory.
    logic                  w_we, w_re;
    logic [ADDR_BITS-1:0]  w_waddr, w_raddr;
    logic [COUNT_BITS-1:0] w_wdata, w_rdata;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_clr_addr;
        w_wdata = '0;
        if (i_cmd.clear_wr) begin
            w_we = 1'b1;
        end else if (i_cmd.inc) begin
            w_we    = 1'b1;
            w_waddr = r_addr;
            w_wdata = (w_rdata == COUNT_MAX) ? w_rdata : w_rdata + 1'b1;
        end else if (i_cmd.scan_wr) begin
            w_we    = 1'b1;
            w_waddr = r_scan_addr;
        end
    end

    assign w_re    = i_cmd.bin || i_cmd.scan_rd;
    assign w_raddr = i_cmd.bin ? w_bin_addr : r_scan_addr;

    pgoc_ram #(
        .WIDTH(COUNT_BITS),
        .DEPTH(CELL_TOTAL)
    ) u_counts (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // Readout: capture cell, form positions, then load the result register.
    localparam int POS_PROD_W = COL_BITS + ROW_BITS + CSIZE_W;

    logic                 r_occ, r_last;
    logic [IDX_OUT_W-1:0] r_col, r_row;
    logic [COORD_W-1:0]   r_pos_x_off, r_pos_y_off;
    logic [POS_PROD_W-1:0] w_px_prod, w_py_prod;

    assign w_px_prod = POS_PROD_W'(r_scan_col) * POS_PROD_W'(r_csize);
    assign w_py_prod = POS_PROD_W'(r_scan_row) * POS_PROD_W'(r_csize);

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_wr) begin
            r_occ       <= CMP_W'(w_rdata) > CMP_W'(r_thresh);
            r_last      <= w_scan_last;
            r_col       <= IDX_OUT_W'(r_scan_col);
            r_row       <= IDX_OUT_W'(r_scan_row);
            r_pos_x_off <= COORD_W'(w_px_prod);
            r_pos_y_off <= COORD_W'(w_py_prod);
        end
    end

    assign o_sts.out_free = !o_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_occupied   <= r_occ;
            o_column     <= r_col;
            o_row        <= r_row;
            o_position_x <= r_origin_x + r_pos_x_off;
            o_position_y <= r_origin_y + r_pos_y_off;
            o_last_cell  <= r_last;
        end
    end
endmodule
`default_nettype wire

### rtl/point_grid_occupancy_counter.sv
// Top level of the point grid occupancy counter.
// Usage:
//   i_in  : one beat per item. func 0 bins (point_x, point_y) into the grid and
//           raises that cell's count, saturating; func 1 reads out the cell at the
//           scan pointer, clears it and advances the pointer.
//   o_out : one beat per readout item: occupied flag, column, row, cell position
//           and a mark on the final cell. Point items give no beat.
//   i_cfg : register writes by index (origin x, origin y, inverse cell size, cell
//           size, count threshold); always ready. Writes must be taken only while
//           the block is idle; the user must ensure it, as the block does not.
// Timing: one item at a time, in steps set by the binning multiply and the
//   count memory's registered read-modify-write. A point item steps through
//   multiply, bin and increment, the last skipped off the grid; a readout through
//   scan read, scan write and output, which loads the beat before the next item.
// Reset: registers take their reset values and the scan pointer returns to cell
//   zero. A clearing pass then zeroes the count memory, one cell per cycle, over
//   every cell of the grid, during which no item is accepted.
// Stall: a result waits in the output register; the next item is still taken and
//   worked on, and a following readout holds until the register is free.
`default_nettype none
module point_grid_occupancy_counter (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    pgoc_in_if.sink      i_in,
    pgoc_out_if.source   o_out,
    pgoc_cfg_if.sink     i_cfg
);
    import pgoc_pkg::*;

    t_pgoc_cmd w_cmd;
    t_pgoc_sts w_sts;

    assign i_cfg.ready = 1'b1;

    pgoc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in.valid),
        .i_in_func (i_in.func),
        .o_in_ready(i_in.ready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    pgoc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_point_x   (i_in.point_x),
        .i_point_y   (i_in.point_y),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_occupied  (o_out.occupied),
        .o_column    (o_out.column),
        .o_row       (o_out.row),
        .o_position_x(o_out.position_x),
        .o_position_y(o_out.position_y),
        .o_last_cell (o_out.last_cell)
    );
endmodule
`default_nettype wire

### tb/point_grid_occupancy_counter_tb.sv
// Testbench for the point grid occupancy counter: directed and random items checked by a predictor.
`timescale 1ns / 100ps
module point_grid_occupancy_counter_tb;
    import pgoc_pkg::*;

    localparam int          COUNT_MAX    = (1 << COUNT_BITS) - 1;
    localparam int          DRAIN_CYCLES = 8;
    localparam longint      RUN_LIMIT    = 2_000_000;
    localparam int          PHASE_ITEMS  = 250;

    typedef struct packed {
        logic                 occupied;
        logic [IDX_OUT_W-1:0] column;
        logic [IDX_OUT_W-1:0] row;
        logic [COORD_W-1:0]   position_x;
        logic [COORD_W-1:0]   position_y;
        logic                 last_cell;
    } t_cell_readout;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pgoc_in_if  in_if ();
    pgoc_out_if out_if ();
    pgoc_cfg_if cfg_if ();

    point_grid_occupancy_counter u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Predictor state: register copies, cell counts and the scan pointer.
    logic signed [COORD_W-1:0] org_x;
    logic signed [COORD_W-1:0] org_y;
    logic [INV_W-1:0]          inv_cell;
    logic [CSIZE_W-1:0]        cell_edge;
    logic [THRESH_W-1:0]       occ_threshold;
    logic [COUNT_BITS-1:0]     grid_count [CELL_TOTAL];
    int                        scan_cell;

    t_cell_readout pending_readouts [$];

    int     error_count = 0;
    int     source_idle_pct;
    int     sink_stall_pct;
    longint cycle_count = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void clear_predictor();
        org_x         = ORIGIN_RESET;
        org_y         = ORIGIN_RESET;
        inv_cell      = INV_RESET;
        cell_edge     = CSIZE_RESET;
        occ_threshold = THRESH_RESET;
        scan_cell     = 0;
        foreach (grid_count[i]) grid_count[i] = '0;
    endfunction

    // Index along one axis; a small negative offset that truncates to zero still counts as cell 0.
    function automatic bit cell_on_axis(input logic signed [COORD_W-1:0] pt,
                                        input logic signed [COORD_W-1:0] org,
                                        input int extent, output int idx);
        longint offset;
        longint magnitude;
        longint quotient;
        offset    = longint'(pt) - longint'(org);
        magnitude = (offset < 0) ? -offset : offset;
        quotient  = (magnitude * longint'(inv_cell)) >> BIN_SHIFT;
        idx       = int'(quotient);
        if (offset < 0 && quotient != 0) return 1'b0;
        return quotient < extent;
    endfunction

    function automatic void predict_point(input logic [COORD_W-1:0] x,
                                          input logic [COORD_W-1:0] y);
        int col;
        int row;
        int addr;
        if (cell_on_axis(x, org_x, GRID_COLUMNS, col) &&
            cell_on_axis(y, org_y, GRID_ROWS, row)) begin
            addr = col + row * GRID_COLUMNS;
            if (grid_count[addr] != COUNT_MAX) grid_count[addr] = grid_count[addr] + 1'b1;
        end
    endfunction

    function automatic void predict_readout();
        t_cell_readout want;
        int            col;
        int            row;
        col             = scan_cell % GRID_COLUMNS;
        row             = scan_cell / GRID_COLUMNS;
        want.occupied   = grid_count[scan_cell] > occ_threshold;
        want.column     = IDX_OUT_W'(col);
        want.row        = IDX_OUT_W'(row);
        want.position_x = COORD_W'(org_x + col * cell_edge);
        want.position_y = COORD_W'(org_y + row * cell_edge);
        want.last_cell  = scan_cell == CELL_TOTAL - 1;
        pending_readouts = {pending_readouts, want};
        grid_count[scan_cell] = '0;
        scan_cell = want.last_cell ? 0 : scan_cell + 1;
    endfunction

    // Coordinate that falls inside cell idx along one axis, with random jitter within the cell.
    function automatic logic [COORD_W-1:0] aim_axis(input int idx,
                                                    input logic signed [COORD_W-1:0] org);
        longint span;
        longint offset;
        span   = (longint'(1) << BIN_SHIFT) / inv_cell;
        offset = ((longint'(idx) << BIN_SHIFT) + inv_cell - 1) / inv_cell;
        if (span > 1) offset = offset + $urandom_range(0, int'(span) - 1);
        return COORD_W'(longint'(org) + offset);
    endfunction

    task automatic aim_point(input int addr, output logic [COORD_W-1:0] x,
                             output logic [COORD_W-1:0] y);
        x = aim_axis(addr % GRID_COLUMNS, org_x);
        y = aim_axis(addr / GRID_COLUMNS, org_y);
    endtask

    task automatic report_error(input string msg);
        $display("ERROR at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Valid is left high after the beat so that back-to-back items need no second assignment.
    task automatic send_item(input logic fn, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y);
        if ($urandom_range(0, 99) < source_idle_pct) begin
            in_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < source_idle_pct);
        end
        in_if.valid   <= 1'b1;
        in_if.func    <= fn;
        in_if.point_x <= x;
        in_if.point_y <= y;
        do @(posedge i_clk); while (!in_if.ready);
        if (fn) predict_readout();
        else predict_point(x, y);
    endtask

    task automatic send_aimed(input int addr);
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        aim_point(addr % CELL_TOTAL, x, y);
        send_item(1'b0, x, y);
    endtask

    task automatic send_readout();
        send_item(1'b1, COORD_W'($urandom), COORD_W'($urandom));
    endtask

    // Point items give no beat, so a fixed drain follows the last readout.
    task automatic settle();
        in_if.valid <= 1'b0;
        while (pending_readouts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            CFG_ORIGIN_X:      org_x         = value[COORD_W-1:0];
            CFG_ORIGIN_Y:      org_y         = value[COORD_W-1:0];
            CFG_INV_CELL_SIZE: inv_cell      = value[INV_W-1:0];
            CFG_CELL_SIZE:     cell_edge     = value[CSIZE_W-1:0];
            CFG_COUNT_THRESH:  occ_threshold = value[THRESH_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] ox, input logic [CFG_DATA_W-1:0] oy,
                                  input logic [CFG_DATA_W-1:0] inv, input logic [CFG_DATA_W-1:0] cs,
                                  input logic [CFG_DATA_W-1:0] thr);
        write_register(CFG_ORIGIN_X, ox);
        write_register(CFG_ORIGIN_Y, oy);
        write_register(CFG_INV_CELL_SIZE, inv);
        write_register(CFG_CELL_SIZE, cs);
        write_register(CFG_COUNT_THRESH, thr);
        cfg_if.valid <= 1'b0;
    endtask

    // Reset settings: cell edges, the just-negative offset, points off the grid and field extremes.
    task automatic test_reset_binning();
        logic [COORD_W-1:0] org;
        org = ORIGIN_RESET;
        send_item(1'b0, org, org);
        send_item(1'b0, org - 20'd1, org);
        send_item(1'b0, org - 20'd60, org);
        send_item(1'b0, org + 20'd51, org);
        send_item(1'b0, org + 20'd52, org + 20'd52);
        send_item(1'b0, org + 20'd13056, org);
        send_item(1'b0, org + 20'd13108, org);
        send_item(1'b0, org, org + 20'd13108);
        send_item(1'b0, 20'h7FFFF, 20'h7FFFF);
        send_item(1'b0, 20'h80000, 20'h80000);
        send_item(1'b1, 20'h7FFFF, 20'h80000);
        send_item(1'b1, 20'h80000, 20'h7FFFF);
        send_item(1'b1, 20'hFFFFF, 20'h00000);
        settle();
    endtask

    // Register extremes; upper data bits beyond a register's width must be dropped.
    task automatic test_register_extremes();
        apply_settings(20'h80000, 20'h7FFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFF00);
        send_aimed(scan_cell);
        send_aimed(scan_cell);
        send_aimed(scan_cell + 1);
        send_item(1'b0, 20'h80000, 20'h7FFFF);
        repeat (3) send_readout();
        settle();
        apply_settings(20'h7FFFF, 20'h80000, 20'hF0001, 20'hA0001, 20'h000FE);
        send_item(1'b0, 20'h7FFFF, 20'h80000);
        send_item(1'b0, 20'h7FFFF, 20'h7FFFF);
        send_item(1'b0, 20'h00000, 20'h80000);
        repeat (2) send_readout();
        settle();
    endtask

    // One cell driven past its maximum count, its neighbour left just at the threshold.
    task automatic test_counter_saturation();
        int addr;
        apply_settings(ORIGIN_RESET, ORIGIN_RESET, 20'h51400, 20'h30033, 20'hAB0FE);
        addr = scan_cell;
        repeat (300) send_aimed(addr);
        repeat (254) send_aimed(addr + 1);
        repeat (2) send_readout();
        settle();
    endtask

    // Well-formed traffic aimed just ahead of the scan pointer, with noise, in four idle/stall phases.
    task automatic test_mixed_traffic();
        int idle_pcts  [4] = '{0, 75, 0, 19};
        int stall_pcts [4] = '{0, 0, 75, 19};
        int pick;
        for (int phase = 0; phase < 4; phase++) begin
            apply_settings(COORD_W'(-int'($urandom_range(0, 200000))),
                           COORD_W'(-int'($urandom_range(0, 200000))),
                           {4'($urandom), 16'($urandom_range(200, 65535))},
                           COORD_W'($urandom),
                           {12'($urandom), 8'($urandom_range(0, 3))});
            source_idle_pct = idle_pcts[phase];
            sink_stall_pct  = stall_pcts[phase];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 20) send_aimed(scan_cell);
                else if (pick < 60) send_aimed(scan_cell + $urandom_range(0, 15));
                else if (pick < 70) begin
                    send_item(1'($urandom), COORD_W'($urandom), COORD_W'($urandom));
                end else send_readout();
            end
            settle();
        end
        source_idle_pct = 0;
        sink_stall_pct  = 0;
    endtask

    // Points at the first and last cells of the far row and over the cells just ahead of the scan
    // pointer, then a readout of each of the cells just ahead.
    task automatic test_scattered_cells();
        int base;
        apply_settings(ORIGIN_RESET, ORIGIN_RESET, {4'($urandom), 16'($urandom_range(1024, 65535))},
                       COORD_W'($urandom), 20'h00000);
        send_aimed(CELL_TOTAL - 1);
        send_aimed(CELL_TOTAL - GRID_COLUMNS);
        base = scan_cell;
        repeat (100) send_aimed(base + $urandom_range(0, 99));
        repeat (100) send_readout();
        settle();
    endtask

    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin : check_readout
        t_cell_readout got;
        t_cell_readout want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = '{out_if.occupied, out_if.column, out_if.row,
                    out_if.position_x, out_if.position_y, out_if.last_cell};
            if (pending_readouts.size() == 0) begin
                report_error("readout beat with no readout item outstanding");
            end else begin
                want = pending_readouts.pop_front();
                if (got !== want) begin
                    report_error($sformatf({"readout occ/col/row/px/py/last got ",
                        "%0b/%0d/%0d/%h/%h/%0b expected %0b/%0d/%0d/%h/%h/%0b"},
                        got.occupied, got.column, got.row, got.position_x, got.position_y,
                        got.last_cell, want.occupied, want.column, want.row,
                        want.position_x, want.position_y, want.last_cell));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("point_grid_occupancy_counter_tb failed");
            $finish;
        end
    end

    initial begin
        source_idle_pct = 0;
        sink_stall_pct  = 0;
        clear_predictor();
        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.func      <= 1'b0;
        in_if.point_x   <= '0;
        in_if.point_y   <= '0;
        cfg_if.valid    <= 1'b0;
        cfg_if.index    <= CFG_ORIGIN_X;
        cfg_if.data     <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The first items also wait out the clearing pass that follows reset.
        test_reset_binning();
        test_register_extremes();
        test_counter_saturation();
        test_mixed_traffic();
        test_scattered_cells();

        if (error_count == 0) begin
            $display("point_grid_occupancy_counter_tb passed");
        end else begin
            $display("point_grid_occupancy_counter_tb failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/pgoc_pkg.sv
rtl/pgoc_if.sv
rtl/pgoc_ram.sv
rtl/pgoc_ctrl.sv
rtl/pgoc_dp.sv
rtl/point_grid_occupancy_counter.sv
tb/point_grid_occupancy_counter_tb.sv
